// ===== src/pqs_pkg.sv =====
// Package for the scan-based priority queue: entry layout, field widths
// and status codes. No dependencies; used by pqs_scan and the top unit.
package pqs_pkg;

  localparam int unsigned ID_W   = 6;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Command codes.
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // One queue slot as it is kept in the entry memory.
  typedef struct packed {
    logic [ID_W-1:0]          owner;
    logic signed [WORD_W-1:0] prio;
    logic signed [WORD_W-1:0] data;
  } entry_t;

endpackage

// ===== src/pqs_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module pqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pqs_scan.sv =====
// Scan unit: follows the entries read out of the slot memory one per cycle,
// keeps the earliest entry of highest priority and flags an owner match.
// Depends on pqs_pkg.
module pqs_scan #(
  parameter int unsigned Capacity = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        smp_valid_i,
  input  logic [$clog2(Capacity)-1:0] smp_idx_i,
  input  pqs_pkg::entry_t             smp_entry_i,
  input  logic [pqs_pkg::ID_W-1:0]    query_id_i,
  output logic [$clog2(Capacity)-1:0] best_idx_o,
  output pqs_pkg::entry_t             best_o,
  output logic                        dup_o
);

  localparam int unsigned IdxW = $clog2(Capacity);

  logic            has_best_q;
  logic            dup_q;
  logic [IdxW-1:0] best_idx_q;
  pqs_pkg::entry_t best_q;
  logic            take;

  // Strictly greater only, so the earliest of equal priorities stays.
  assign take = smp_valid_i && (!has_best_q || (smp_entry_i.prio > best_q.prio));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_best_q <= 1'b0;
      dup_q      <= 1'b0;
    end else if (clear_i) begin
      has_best_q <= 1'b0;
      dup_q      <= 1'b0;
    end else if (smp_valid_i) begin
      has_best_q <= 1'b1;
      if (smp_entry_i.owner == query_id_i) begin
        dup_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q     <= smp_entry_i;
      best_idx_q <= smp_idx_i;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_o     = best_q;
  assign dup_o      = dup_q;

endmodule

// ===== src/priority_queue_scan_extract_max_unit.sv =====
// Priority queue kept as an unsorted list in one slot memory (registered read).
// Insert: one memory read per slot for the duplicate check, then the tail
// write if the entry is accepted. Extract: one read per slot for the maximum
// search, then one move per slot behind the removed one. One item at a time;
// a finished result may wait in the output register while the next item is
// taken. Reset empties the queue.
module priority_queue_scan_extract_max_unit #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned ID_COUNT = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic [pqs_pkg::ID_W-1:0]             item_id_i,
  input  logic signed [pqs_pkg::WORD_W-1:0]    item_data_i,
  input  logic signed [pqs_pkg::WORD_W-1:0]    item_priority_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [pqs_pkg::STAT_W-1:0]           status_o,
  output logic [pqs_pkg::ID_W-1:0]             out_id_o,
  output logic signed [pqs_pkg::WORD_W-1:0]    out_data_o,
  output logic signed [pqs_pkg::WORD_W-1:0]    out_priority_o
);

  localparam int unsigned IdxW   = $clog2(CAPACITY);
  localparam int unsigned OccW   = $clog2(CAPACITY + 1);
  localparam int unsigned IdVals = 2 ** pqs_pkg::ID_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic                        cmd_q;
  pqs_pkg::entry_t             ins_q;
  logic [OccW-1:0]             ptr_q, ptr_d;
  logic [OccW-1:0]             occ_q, occ_d;
  logic                        rd_vld_q;
  logic [IdxW-1:0]             rd_idx_q;
  logic [pqs_pkg::STAT_W-1:0]  res_status_q, res_status_d;
  pqs_pkg::entry_t             res_entry_q, res_entry_d;
  logic                        out_valid_q;
  logic [pqs_pkg::STAT_W-1:0]  out_status_q;
  pqs_pkg::entry_t             out_entry_q;

  logic                        in_xfer;
  logic                        active;
  logic                        issuing;
  logic                        phase_done;
  logic                        scan_clear;
  logic                        out_load;
  logic                        mem_we;
  logic [IdxW-1:0]             mem_waddr;
  pqs_pkg::entry_t             mem_wdata;
  pqs_pkg::entry_t             mem_rdata;
  logic [IdxW-1:0]             best_idx;
  pqs_pkg::entry_t             best;
  logic                        dup;
  logic                        ins_ok;
  logic [pqs_pkg::ID_W-1:0]    id_mod_tab [IdVals];
  logic [pqs_pkg::ID_W-1:0]    id_mod;

  // Identifiers are folded into the range of ID_COUNT by a constant table.
  for (genvar g = 0; g < IdVals; g++) begin : g_id_mod
    localparam int unsigned ModVal = g % ID_COUNT;
    assign id_mod_tab[g] = pqs_pkg::ID_W'(ModVal);
  end
  assign id_mod = id_mod_tab[item_id_i];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign scan_clear = in_xfer;
  assign active     = (state_q == S_SCAN) || (state_q == S_SHIFT);
  assign issuing    = active && (ptr_q < occ_q);
  assign phase_done = active && !issuing && !rd_vld_q;
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  assign ins_ok     = (cmd_q == pqs_pkg::CMD_INSERT) && !dup &&
                      (occ_q != OccW'(CAPACITY));

  pqs_ram #(
    .Width($bits(pqs_pkg::entry_t)),
    .Depth(CAPACITY)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(ptr_q[IdxW-1:0]),
    .rdata_o(mem_rdata)
  );

  pqs_scan #(
    .Capacity(CAPACITY)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (scan_clear),
    .smp_valid_i((state_q == S_SCAN) && rd_vld_q),
    .smp_idx_i  (rd_idx_q),
    .smp_entry_i(mem_rdata),
    .query_id_i (ins_q.owner),
    .best_idx_o (best_idx),
    .best_o     (best),
    .dup_o      (dup)
  );

  // Memory writes: the tail write of an insert, or one slot moved up per
  // returned read while the list behind an extracted entry is compacted.
  // Reads run ahead of writes, so no slot is read after it is overwritten.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = occ_q[IdxW-1:0];
    mem_wdata = ins_q;
    if ((state_q == S_SCAN) && phase_done && ins_ok) begin
      mem_we = 1'b1;
    end else if ((state_q == S_SHIFT) && rd_vld_q) begin
      mem_we    = 1'b1;
      mem_waddr = rd_idx_q - IdxW'(1);
      mem_wdata = mem_rdata;
    end
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    occ_d        = occ_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    if (issuing) begin
      ptr_d = ptr_q + OccW'(1);
    end
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SCAN;
          ptr_d   = '0;
        end
      end
      S_SCAN: begin
        if (phase_done) begin
          res_entry_d = '0;
          state_d     = S_FINISH;
          if (cmd_q == pqs_pkg::CMD_INSERT) begin
            if (dup) begin
              res_status_d = pqs_pkg::ST_DUP;
            end else if (!ins_ok) begin
              res_status_d = pqs_pkg::ST_FULL;
            end else begin
              res_status_d = pqs_pkg::ST_OK;
              occ_d        = occ_q + OccW'(1);
            end
          end else if (occ_q == '0) begin
            res_status_d = pqs_pkg::ST_EMPTY;
          end else begin
            res_status_d = pqs_pkg::ST_OK;
            res_entry_d  = best;
            ptr_d        = OccW'(best_idx) + OccW'(1);
            state_d      = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (phase_done) begin
          occ_d   = occ_q - OccW'(1);
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= issuing;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= ptr_q[IdxW-1:0];
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    if (in_xfer) begin
      cmd_q       <= command_i;
      ins_q.owner <= id_mod;
      ins_q.prio  <= item_priority_i;
      ins_q.data  <= item_data_i;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_entry_q  <= res_entry_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_id_o       = out_entry_q.owner;
  assign out_data_o     = out_entry_q.data;
  assign out_priority_o = out_entry_q.prio;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && phase_done && ins_ok) |=> (occ_q == $past(occ_q) + OccW'(1)))
    else $error("accepted insert did not grow the queue");

  a_extract_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SHIFT) && phase_done) |=> (occ_q == $past(occ_q) - OccW'(1)))
    else $error("extract did not shrink the queue");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SHIFT) && mem_we) |-> (OccW'(mem_waddr) + OccW'(1) < occ_q))
    else $error("compaction write beyond the occupied slots");

endmodule
